// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the RTL; the top-level module includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/core/mlse_pkg.sv =====
`default_nettype none

package mlse_pkg;

    localparam int MSG_BITS = 8;
    localparam int BUF_BITS = 16;

    typedef enum logic {
        REG_BITS_PER_BYTE = 1'b0,
        REG_MODE          = 1'b1
    } t_reg_idx;

    typedef enum logic {
        MODE_EMBED   = 1'b0,
        MODE_EXTRACT = 1'b1
    } t_mode;

    typedef enum logic {
        KIND_MESSAGE = 1'b0,
        KIND_COVER   = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_OVERFLOW = 2'd1,
        STATUS_UNDERRUN = 2'd2
    } t_status;

    typedef struct packed {
        logic [15:0] bits;
        logic [4:0]  cnt;
        logic        ended;
    } t_state;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        t_status    status;
    } t_result;

    // Mask of the c lowest bits of the buffer, c in 0..16.
    function automatic logic [15:0] low_mask16(input logic [4:0] c);
        return 16'hFFFF >> (5'd16 - c);
    endfunction

    // Mask of the c lowest bits of a byte, c in 0..8.
    function automatic logic [7:0] low_mask8(input logic [3:0] c);
        return 8'hFF >> (4'd8 - c);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mlse_step.sv =====
`default_nettype none

module mlse_step
    import mlse_pkg::*;
(
    input  t_state     i_state,
    input  t_mode      i_mode,
    input  logic [3:0] i_width,
    input  t_kind      i_kind,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_state     o_state,
    output t_result    o_result
);

    logic [7:0]  fmask;
    logic [4:0]  width5;
    logic [4:0]  emb_shift;
    logic [4:0]  emb_cnt;
    logic [7:0]  emb_bits;
    logic [3:0]  part_shift;
    logic [7:0]  part_repl;
    logic [7:0]  part_bits;
    logic [15:0] ext_buf;
    logic [4:0]  ext_cnt;
    logic [4:0]  ext_rem;

    assign fmask      = low_mask8(i_width);
    assign width5     = {1'b0, i_width};
    assign emb_shift  = i_state.cnt - width5;
    assign emb_cnt    = i_state.cnt - width5;
    assign emb_bits   = 8'(i_state.bits >> emb_shift) & fmask;
    assign part_shift = i_width - i_state.cnt[3:0];
    assign part_repl  = 8'(low_mask8(i_state.cnt[3:0]) << part_shift);
    assign part_bits  = 8'((i_state.bits[7:0] & low_mask8(i_state.cnt[3:0])) << part_shift);
    assign ext_buf    = (i_state.bits << i_width) | {8'd0, i_byte & fmask};
    assign ext_cnt    = i_state.cnt + width5;
    assign ext_rem    = ext_cnt - 5'(MSG_BITS);

    always_comb begin
        o_state  = i_state;
        o_result = '{data: 8'd0, present: 1'b0, status: STATUS_OK};
        if (i_mode == MODE_EMBED) begin
            if (i_kind == KIND_MESSAGE) begin
                if (i_state.cnt > 5'(BUF_BITS - MSG_BITS)) begin
                    o_result.status = STATUS_OVERFLOW;
                end else begin
                    o_state.bits  = {i_state.bits[7:0], i_byte};
                    o_state.cnt   = i_state.cnt + 5'(MSG_BITS);
                    o_state.ended = i_last;
                end
            end else begin
                o_result.present = 1'b1;
                if (i_state.cnt >= width5) begin
                    o_result.data = (i_byte & ~fmask) | emb_bits;
                    o_state.cnt   = emb_cnt;
                    o_state.bits  = i_state.bits & low_mask16(emb_cnt);
                end else if (i_state.ended) begin
                    if (i_state.cnt == 5'd0) begin
                        o_result.data = i_byte;
                    end else begin
                        o_result.data = (i_byte & ~part_repl) | part_bits;
                        o_state.cnt   = 5'd0;
                        o_state.bits  = 16'd0;
                    end
                end else begin
                    o_result.data   = i_byte;
                    o_result.status = STATUS_UNDERRUN;
                end
            end
        end else if (i_kind == KIND_COVER) begin
            o_state.bits = ext_buf;
            o_state.cnt  = ext_cnt;
            if (ext_cnt >= 5'(MSG_BITS)) begin
                o_result.data    = 8'(ext_buf >> ext_rem);
                o_result.present = 1'b1;
                o_state.cnt      = ext_rem;
                o_state.bits     = ext_buf & low_mask16(ext_rem);
            end
            if (i_last) begin
                o_state.cnt  = 5'd0;
                o_state.bits = 16'd0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/multi_lsb_stego_embed_extract.sv =====
// Stages: an input transfer loads the input register, and the result register loads
// from it when the output can advance; the result then waits there for its transfer.
// Throughput: one item per cycle while the output is not stalled; the bit buffer update fits between the two registers.
// Reset: i_rst_n is synchronous and active low; it empties both stages and the bit
// buffer and sets one bit per byte in embed mode.
`default_nettype none
`include "assert_macros.svh"

module multi_lsb_stego_embed_extract
    import mlse_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [3:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_byte
    input  logic        s_axis_tuser,   // kind
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // out_byte, status, zero fill
    output logic        m_axis_tuser    // byte_present
);

    logic       r_in_valid;
    t_kind      r_in_kind;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;
    t_state     r_state;
    t_state     n_state;
    t_result    n_result;
    t_mode      r_mode;
    logic [3:0] r_width;
    logic [3:0] n_width;
    logic       advance;

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;

    always_comb begin
        if (i_cfg_data == 4'd0) begin
            n_width = 4'd1;
        end else if (i_cfg_data > 4'd8) begin
            n_width = 4'd8;
        end else begin
            n_width = i_cfg_data;
        end
    end

    mlse_step u_step (
        .i_state  (r_state),
        .i_mode   (r_mode),
        .i_width  (r_width),
        .i_kind   (r_in_kind),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
            r_mode      <= MODE_EMBED;
            r_width     <= 4'd1;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_state <= n_state;
                end
            end
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_BITS_PER_BYTE: begin
                        r_width <= n_width;
                    end
                    REG_MODE: begin
                        r_mode  <= t_mode'(i_cfg_data[0]);
                        r_state <= '0;
                    end
                    default: begin
                        r_width <= r_width;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_kind <= t_kind'(s_axis_tuser);
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
        if (advance && r_in_valid) begin
            r_out <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out.status, r_out.data};
    assign m_axis_tuser  = r_out.present;

    `ASSERT_IMPLY(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_state.cnt <= 5'd16,
        "Bit count exceeds buffer size.")
    `ASSERT_IMPLY(a_extract_cnt, i_clk, i_rst_n, r_mode == MODE_EXTRACT,
        r_state.cnt < 5'd8, "Extract mode holds a whole byte.")
    `ASSERT_IMPLY(a_absent_zero, i_clk, i_rst_n, r_out_valid && !r_out.present,
        r_out.data == 8'd0, "Result without a byte carries data.")
    `ASSERT_IMPLY(a_status_embed, i_clk, i_rst_n, r_out_valid && r_out.status != STATUS_OK,
        r_mode == MODE_EMBED, "Error status outside embed mode.")

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

module tb;
    import mlse_pkg::*;

    localparam int LATENCY      = 2;
    localparam int PHASES       = 20;
    localparam int PHASE_ITEMS  = 35;

    typedef enum logic {
        ROW_ITEM = 1'b0,
        ROW_CFG  = 1'b1
    } t_row_op;

    typedef struct {
        t_row_op  op;
        t_reg_idx reg_sel;
        t_kind    kind;
        logic [7:0] data;
        logic     last;
        bit       has_exp;
        t_result  exp;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = REG_BITS_PER_BYTE;
    logic [3:0]  i_cfg_data = 4'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;   // in_byte
    logic        s_axis_tuser = KIND_MESSAGE;   // kind
    logic        s_axis_tlast = 1'b0;   // last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // out_byte, status, zero fill
    logic        m_axis_tuser;          // byte_present

    // Model of the block: register copies and bit buffer.
    logic [3:0]  width_reg = 4'd1;
    t_mode       mode_reg = MODE_EMBED;
    logic [15:0] held_bits = 16'd0;
    int          held_cnt = 0;
    logic        msg_done = 1'b0;

    t_result     result_q[$];
    int          src_idle_pct = 0;
    int          snk_stall_pct = 0;
    int          errors = 0;
    int          n_checked = 0;
    int          n_embed = 0;
    int          n_extract = 0;
    int          n_overflow = 0;
    int          n_underrun = 0;
    int          width_list[10] = '{1, 8, 0, 15, 2, 3, 4, 5, 6, 7};

    multi_lsb_stego_embed_extract u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_result stego_step(input t_kind k, input logic [7:0] b, input logic l);
        int n;
        logic [31:0] fmask;
        logic [31:0] bits;
        logic [31:0] repl;
        logic [31:0] acc;
        t_result r;
        n = (width_reg == 4'd0) ? 1 : (width_reg > 4'd8) ? 8 : int'(width_reg);
        fmask = (32'd1 << n) - 32'd1;
        r = '0;
        r.status = STATUS_OK;
        if (mode_reg == MODE_EMBED) begin
            if (k == KIND_MESSAGE) begin
                if (held_cnt + MSG_BITS > BUF_BITS) begin
                    r.status = STATUS_OVERFLOW;
                end else begin
                    held_bits = {held_bits[7:0], b};
                    held_cnt += MSG_BITS;
                    msg_done = l;
                end
            end else begin
                r.present = 1'b1;
                if (held_cnt >= n) begin
                    bits = ({16'd0, held_bits} >> (held_cnt - n)) & fmask;
                    r.data = (b & ~fmask[7:0]) | bits[7:0];
                    held_cnt -= n;
                    acc = {16'd0, held_bits} & ((32'd1 << held_cnt) - 32'd1);
                    held_bits = acc[15:0];
                end else if (msg_done) begin
                    if (held_cnt == 0) begin
                        r.data = b;
                    end else begin
                        repl = ((32'd1 << held_cnt) - 32'd1) << (n - held_cnt);
                        bits = ({16'd0, held_bits} & ((32'd1 << held_cnt) - 32'd1))
                               << (n - held_cnt);
                        r.data = (b & ~repl[7:0]) | bits[7:0];
                        held_cnt = 0;
                        held_bits = 16'd0;
                    end
                end else begin
                    r.data = b;
                    r.status = STATUS_UNDERRUN;
                end
            end
        end else if (k == KIND_COVER) begin
            acc = (({16'd0, held_bits} << n) | ({24'd0, b} & fmask)) & 32'hFFFF;
            held_bits = acc[15:0];
            held_cnt += n;
            if (held_cnt >= MSG_BITS) begin
                bits = acc >> (held_cnt - MSG_BITS);
                r.data = bits[7:0];
                r.present = 1'b1;
                held_cnt -= MSG_BITS;
                acc = acc & ((32'd1 << held_cnt) - 32'd1);
                held_bits = acc[15:0];
            end
            if (l) begin
                held_cnt = 0;
                held_bits = 16'd0;
            end
        end
        return r;
    endfunction

    function automatic t_row item_row(input t_kind k, input logic [7:0] b, input logic l);
        t_row r;
        r.op = ROW_ITEM;
        r.reg_sel = REG_BITS_PER_BYTE;
        r.kind = k;
        r.data = b;
        r.last = l;
        r.has_exp = 1'b0;
        r.exp = '0;
        return r;
    endfunction

    function automatic t_row fixed_row(input t_kind k, input logic [7:0] b, input logic l,
                                       input logic [7:0] ob, input logic pr, input t_status st);
        t_row r;
        r = item_row(k, b, l);
        r.has_exp = 1'b1;
        r.exp.data = ob;
        r.exp.present = pr;
        r.exp.status = st;
        return r;
    endfunction

    function automatic t_row cfg_row(input t_reg_idx idx, input logic [3:0] v);
        t_row r;
        r = item_row(KIND_MESSAGE, {4'd0, v}, 1'b0);
        r.op = ROW_CFG;
        r.reg_sel = idx;
        return r;
    endfunction

    task automatic push_item(input t_kind k, input logic [7:0] b, input logic l,
                             input bit has_exp, input t_result want);
        t_result r;
        @(negedge i_clk);
        while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= k;
        s_axis_tdata  <= b;
        s_axis_tlast  <= l;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (mode_reg == MODE_EMBED) n_embed++;
        else n_extract++;
        r = stego_step(k, b, l);
        result_q = {result_q, (has_exp ? want : r)};
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (result_q.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 1) @(negedge i_clk);
    endtask

    task automatic reg_write(input t_reg_idx idx, input logic [3:0] v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == REG_BITS_PER_BYTE) begin
            width_reg = v;
        end else begin
            mode_reg = t_mode'(v[0]);
            held_bits = 16'd0;
            held_cnt = 0;
            msg_done = 1'b0;
        end
    endtask

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (result_q.size() == 0) begin
                $error("result transfer with no expectation pending: tdata %h tuser %b",
                       m_axis_tdata, m_axis_tuser);
                errors++;
            end else begin
                want = result_q.pop_front();
                n_checked++;
                if (want.status == STATUS_OVERFLOW) n_overflow++;
                if (want.status == STATUS_UNDERRUN) n_underrun++;
                if (m_axis_tdata[7:0] !== want.data) begin
                    $error("out_byte: expected %h, got %h", want.data, m_axis_tdata[7:0]);
                    errors++;
                end
                if (m_axis_tuser !== want.present) begin
                    $error("byte_present: expected %b, got %b", want.present, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata[9:8] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tdata[9:8]);
                    errors++;
                end
                if (m_axis_tdata[15:10] !== 6'd0) begin
                    $error("zero fill: expected %h, got %h", 6'd0, m_axis_tdata[15:10]);
                    errors++;
                end
            end
        end
    end

    initial begin
        t_row rows[$];
        t_kind k;
        logic [7:0] b;
        logic l;
        logic [3:0] mv;
        t_mode md;
        int msg_left;
        int sent;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Embed at reset width: underrun, fill the buffer, then an overflow.
        rows = {rows, fixed_row(KIND_COVER, 8'hFF, 1'b0, 8'hFF, 1'b1, STATUS_UNDERRUN)};
        rows = {rows, fixed_row(KIND_MESSAGE, 8'h00, 1'b0, 8'h00, 1'b0, STATUS_OK)};
        rows = {rows, fixed_row(KIND_MESSAGE, 8'hFF, 1'b0, 8'h00, 1'b0, STATUS_OK)};
        rows = {rows, fixed_row(KIND_MESSAGE, 8'h5A, 1'b1, 8'h00, 1'b0, STATUS_OVERFLOW)};
        rows = {rows, item_row(KIND_COVER, 8'hAA, 1'b0)};
        // A width of zero acts as one, a width above eight acts as eight.
        rows = {rows, cfg_row(REG_BITS_PER_BYTE, 4'd0)};
        rows = {rows, item_row(KIND_COVER, 8'h55, 1'b0)};
        rows = {rows, cfg_row(REG_BITS_PER_BYTE, 4'd15)};
        rows = {rows, item_row(KIND_COVER, 8'h00, 1'b1)};
        rows = {rows, item_row(KIND_COVER, 8'hFF, 1'b0)};
        // Final message byte, a partial last group, then covers pass through.
        rows = {rows, cfg_row(REG_BITS_PER_BYTE, 4'd3)};
        rows = {rows, item_row(KIND_MESSAGE, 8'hC3, 1'b1)};
        rows = {rows, item_row(KIND_COVER, 8'hFF, 1'b0)};
        rows = {rows, item_row(KIND_COVER, 8'h00, 1'b0)};
        rows = {rows, item_row(KIND_COVER, 8'hA5, 1'b0)};
        rows = {rows, item_row(KIND_COVER, 8'h5A, 1'b0)};
        rows = {rows, item_row(KIND_COVER, 8'hFF, 1'b0)};
        rows = {rows, item_row(KIND_COVER, 8'h3C, 1'b0)};
        rows = {rows, cfg_row(REG_BITS_PER_BYTE, 4'd5)};
        rows = {rows, item_row(KIND_MESSAGE, 8'h81, 1'b1)};
        rows = {rows, item_row(KIND_COVER, 8'h00, 1'b0)};
        rows = {rows, item_row(KIND_COVER, 8'hFF, 1'b0)};
        rows = {rows, item_row(KIND_COVER, 8'h0F, 1'b0)};
        // Extract: full-byte width, an ignored message byte, leftovers cleared by last.
        rows = {rows, cfg_row(REG_MODE, {3'd0, MODE_EXTRACT})};
        rows = {rows, cfg_row(REG_BITS_PER_BYTE, 4'd8)};
        rows = {rows, fixed_row(KIND_COVER, 8'h96, 1'b0, 8'h96, 1'b1, STATUS_OK)};
        rows = {rows, fixed_row(KIND_MESSAGE, 8'hFF, 1'b1, 8'h00, 1'b0, STATUS_OK)};
        rows = {rows, cfg_row(REG_BITS_PER_BYTE, 4'd3)};
        rows = {rows, item_row(KIND_COVER, 8'h07, 1'b0)};
        rows = {rows, item_row(KIND_COVER, 8'h05, 1'b0)};
        rows = {rows, item_row(KIND_COVER, 8'h02, 1'b1)};
        rows = {rows, item_row(KIND_COVER, 8'h07, 1'b1)};
        rows = {rows, cfg_row(REG_MODE, {3'd0, MODE_EMBED})};

        foreach (rows[i]) begin
            if (rows[i].op == ROW_CFG) begin
                drain();
                reg_write(rows[i].reg_sel, rows[i].data[3:0]);
            end else begin
                push_item(rows[i].kind, rows[i].data, rows[i].last,
                          rows[i].has_exp, rows[i].exp);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            drain();
            md = (p % 2) ? MODE_EXTRACT : MODE_EMBED;
            mv = {3'($urandom_range(0, 7)), md};
            if ($urandom_range(0, 1)) begin
                reg_write(REG_BITS_PER_BYTE, 4'(width_list[p / 2]));
                reg_write(REG_MODE, mv);
            end else begin
                reg_write(REG_MODE, mv);
                reg_write(REG_BITS_PER_BYTE, 4'(width_list[p / 2]));
            end
            case ((p + p / 4) % 4)
                0: begin
                    src_idle_pct = 0;
                    snk_stall_pct = 0;
                end
                1: begin
                    src_idle_pct = 62;
                    snk_stall_pct = 0;
                end
                2: begin
                    src_idle_pct = 0;
                    snk_stall_pct = 62;
                end
                default: begin
                    src_idle_pct = 22;
                    snk_stall_pct = 22;
                end
            endcase
            msg_left = 0;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                b = 8'($urandom);
                if (md == MODE_EMBED) begin
                    sent++;
                    if ($urandom_range(0, 99) < 85) begin
                        if (msg_left == 0 && (held_cnt == 0 || (!msg_done && held_cnt <= 8)))
                            msg_left = $urandom_range(1, 5);
                        if (msg_left > 0 && held_cnt <= 8 && $urandom_range(0, 3) != 0) begin
                            k = KIND_MESSAGE;
                            l = (msg_left == 1);
                            msg_left--;
                        end else begin
                            k = KIND_COVER;
                            l = 1'($urandom_range(0, 1));
                        end
                    end else begin
                        k = t_kind'($urandom_range(0, 1));
                        l = 1'($urandom_range(0, 1));
                    end
                end else begin
                    k = ($urandom_range(0, 99) < 6) ? KIND_MESSAGE : KIND_COVER;
                    l = ($urandom_range(0, 99) < 12);
                    if (k == KIND_COVER) sent++;
                end
                push_item(k, b, l, 1'b0, '0);
            end
        end

        src_idle_pct = 0;
        snk_stall_pct = 0;
        drain();
        repeat (8) @(posedge i_clk);
        $display("Checked %0d results from %0d embed and %0d extract transfers.",
                 n_checked, n_embed, n_extract);
        $display("Widths 0 through 8 and 15 in both modes, four idle mixes, %0d overflows, %0d underruns.",
                 n_overflow, n_underrun);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
